>>> src/ean8_barcode_encoder_macros.svh
// Assertion macros used by the top level of the EAN-8 encoder RTL.
// Each macro expands to one labeled concurrent assertion on clk_i / rst_ni.
`ifndef EAN8_BARCODE_ENCODER_MACROS_SVH
`define EAN8_BARCODE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EAN8_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ean8 assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define EAN8_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ean8 assertion failed");

`endif

>>> src/ean8_pkg.sv
// Shared types, constants and code tables of the EAN-8 encoder.
// No dependencies; used by every module of the block.
package ean8_pkg;

  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 8;  // seven input digits plus the check digit
  localparam int unsigned SumW      = 8;  // largest weighted sum is 135
  localparam int unsigned SegBitsW  = 7;
  localparam int unsigned SegLenW   = 3;
  localparam int unsigned SegIdxW   = 4;

  localparam logic [SegBitsW-1:0] GuardBits  = 7'b000_0101;
  localparam logic [SegBitsW-1:0] CentreBits = 7'b000_1010;
  localparam logic [SegLenW-1:0]  GuardLen   = 3'd3;
  localparam logic [SegLenW-1:0]  CentreLen  = 3'd5;
  localparam logic [SegLenW-1:0]  CodeLen    = 3'd7;

  // Segment positions within one code.
  localparam logic [SegIdxW-1:0] SegStart  = 4'd0;
  localparam logic [SegIdxW-1:0] SegCentre = 4'd5;
  localparam logic [SegIdxW-1:0] SegEnd    = 4'd10;

  // Reciprocal of ten for the check digit: q = (sum * 205) >> 11, exact for sum < 1024.
  localparam logic [7:0] RecipTen   = 8'd205;
  localparam int unsigned RecipShift = 11;

  // One classified item waiting for the bar sequencer.
  typedef struct packed {
    logic [NumDigits-1:0][DigitW-1:0] digits;
    logic [DigitW-1:0]                check;
    logic                             err;
  } item_t;

  // Odd-parity L code of a digit; the R code is its complement.
  function automatic logic [SegBitsW-1:0] l_code(input logic [DigitW-1:0] digit);
    logic [SegBitsW-1:0] code;
    case (digit)
      4'd0:    code = 7'h0D;
      4'd1:    code = 7'h19;
      4'd2:    code = 7'h13;
      4'd3:    code = 7'h3D;
      4'd4:    code = 7'h23;
      4'd5:    code = 7'h31;
      4'd6:    code = 7'h2F;
      4'd7:    code = 7'h3B;
      4'd8:    code = 7'h37;
      4'd9:    code = 7'h0B;
      default: code = '0;
    endcase
    return code;
  endfunction

endpackage

>>> src/ean8_front.sv
// Front end of the EAN-8 encoder: validates the digits and computes the check digit.
// Depends on ean8_pkg for the item type and constants.
module ean8_front (
  input  logic [ean8_pkg::DigitW*7-1:0] digits_i,  // first digit in the lowest nibble
  output ean8_pkg::item_t                item_o
);

  logic [6:0]                  bad;
  logic [ean8_pkg::SumW-1:0]   sum;
  logic [15:0]                 prod;
  logic [3:0]                  quot;
  logic [ean8_pkg::SumW-1:0]   rem;
  logic [ean8_pkg::DigitW-1:0] chk;

  // Flag any digit above nine and form the weighted sum.
  always_comb begin
    sum = '0;
    for (int i = 0; i < 7; i++) begin
      bad[i] = (digits_i[i*ean8_pkg::DigitW +: ean8_pkg::DigitW] > 4'd9);
      if ((i % 2) == 0) begin
        sum = sum + ean8_pkg::SumW'(3 * digits_i[i*ean8_pkg::DigitW +: ean8_pkg::DigitW]);
      end else begin
        sum = sum + ean8_pkg::SumW'(digits_i[i*ean8_pkg::DigitW +: ean8_pkg::DigitW]);
      end
    end
  end

  // Sum modulo ten through a reciprocal multiply, then the check digit.
  always_comb begin
    prod = 16'(sum) * 16'(ean8_pkg::RecipTen);
    quot = prod[ean8_pkg::RecipShift +: 4];
    rem  = sum - ((ean8_pkg::SumW'(quot) << 3) + (ean8_pkg::SumW'(quot) << 1));
    chk  = (rem == '0) ? 4'd0 : 4'(4'd10 - rem[3:0]);
  end

  // Assemble the item for the queue.
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      item_o.digits[i] = digits_i[i*ean8_pkg::DigitW +: ean8_pkg::DigitW];
    end
    item_o.digits[7] = chk;
    item_o.check     = chk;
    item_o.err       = |bad;
  end

endmodule

>>> src/ean8_fifo.sv
// Short queue between the front end and the bar sequencer of the EAN-8 encoder.
// Depends on ean8_pkg for the item type.
module ean8_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ean8_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ean8_pkg::item_t item_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ean8_pkg::item_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> src/ean8_back.sv
// EAN-8 bar sequencer: walks an item's eleven segments, or one if flagged.
// Depends on ean8_pkg for the item type, code table and segment constants.
module ean8_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ean8_pkg::item_t               item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ean8_pkg::SegBitsW-1:0] seg_bits_o,
  output logic [ean8_pkg::SegLenW-1:0]  seg_len_o,
  output logic [ean8_pkg::DigitW-1:0]   check_o,
  output logic                          err_o,
  output logic                          last_o
);

  logic [ean8_pkg::SegIdxW-1:0]  seg_q, seg_d;
  logic                          out_valid_q, out_valid_d;
  logic [ean8_pkg::SegBitsW-1:0] bits_q, bits_d;
  logic [ean8_pkg::SegLenW-1:0]  len_q, len_d;
  logic [ean8_pkg::DigitW-1:0]   chk_q;
  logic                          err_q, last_q, last_d;
  logic                          load;
  logic [ean8_pkg::SegIdxW-1:0]  idx_wide;
  logic [2:0]                    idx;
  logic [ean8_pkg::SegBitsW-1:0] code;

  // A new segment enters the output register when it is empty or being drained.
  assign load  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last_d;

  // Pick the digit of the current segment and its L code.
  always_comb begin
    idx_wide = (seg_q < ean8_pkg::SegCentre) ? seg_q - 4'd1 : seg_q - 4'd2;
    idx      = idx_wide[2:0];
    code     = ean8_pkg::l_code(item_i.digits[idx]);
  end

  // Segment contents by position.
  always_comb begin
    last_d = item_i.err || (seg_q == ean8_pkg::SegEnd);
    if (item_i.err) begin
      bits_d = '0;
      len_d  = '0;
    end else if (seg_q == ean8_pkg::SegStart || seg_q == ean8_pkg::SegEnd) begin
      bits_d = ean8_pkg::GuardBits;
      len_d  = ean8_pkg::GuardLen;
    end else if (seg_q == ean8_pkg::SegCentre) begin
      bits_d = ean8_pkg::CentreBits;
      len_d  = ean8_pkg::CentreLen;
    end else if (seg_q < ean8_pkg::SegCentre) begin
      bits_d = code;
      len_d  = ean8_pkg::CodeLen;
    end else begin
      bits_d = ~code;
      len_d  = ean8_pkg::CodeLen;
    end
  end

  // Segment counter and output valid.
  always_comb begin
    seg_d       = seg_q;
    out_valid_d = out_valid_q;
    if (load) begin
      seg_d       = last_d ? ean8_pkg::SegStart : seg_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= ean8_pkg::SegStart;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      bits_q <= bits_d;
      len_q  <= len_d;
      chk_q  <= item_i.err ? 4'd0 : item_i.check;
      err_q  <= item_i.err;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign seg_bits_o  = bits_q;
  assign seg_len_o   = len_q;
  assign check_o     = chk_q;
  assign err_o       = err_q;
  assign last_o      = last_q;

endmodule

>>> src/ean8_barcode_encoder.sv
// EAN-8 encoder: accepts seven digits per input transfer and emits the bar pattern.
// The slave channel takes one code in s_axis_tdata, seven 4-bit digits, first digit
// in bits [3:0]. The master channel gives eleven segment transfers per code: start
// guard, four L-coded digits, centre guard, three R-coded digits and the R-coded
// check digit, end guard. tlast marks the final segment; tuser flags a digit above
// nine, in which case a single transfer with zero pattern, length and check is sent.
// A code's input transfer is registered in the queue, and its first segment then in the
// output register of the sequencer. Throughput: one segment per cycle while the
// receiver is ready and a code is queued, set by the sequencer's single output register.
// The front end and a queue of QueueDepth codes decouple input from output, so new
// codes are taken while segments of earlier codes are still being sent.
// Reset clears the queue, the segment counter and the output valid; no clearing pass.
// When the receiver stalls, the current segment holds in the output register and
// the queue fills; s_axis_tready drops only when the queue is full.
`include "ean8_barcode_encoder_macros.svh"
module ean8_barcode_encoder #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // first_digit .. seventh_digit (4 bits each), 4 zero bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // segment_bits (7), segment_length (3), check_digit (4), 2 zero bits
  output logic [0:0]  m_axis_tuser,   // digit_error
  output logic        m_axis_tlast    // last_segment
);

  ean8_pkg::item_t              front_item;
  ean8_pkg::item_t              queue_item;
  logic                         queue_full;
  logic                         queue_valid;
  logic                         queue_pop;
  logic                         push;
  logic [ean8_pkg::SegBitsW-1:0] seg_bits;
  logic [ean8_pkg::SegLenW-1:0]  seg_len;
  logic [ean8_pkg::DigitW-1:0]   check;
  logic                          err;

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Classify the incoming code and compute its check digit.
  ean8_front u_front (
    .digits_i (s_axis_tdata[27:0]),
    .item_o   (front_item)
  );

  // Hold classified codes until the sequencer takes them.
  ean8_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // Emit the segments of each code.
  ean8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .item_i      (queue_item),
    .pop_o       (queue_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .seg_bits_o  (seg_bits),
    .seg_len_o   (seg_len),
    .check_o     (check),
    .err_o       (err),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, check, seg_len, seg_bits};
  assign m_axis_tuser = err;

  // A flagged code is a single transfer with zero length and check digit.
  `EAN8_ASSERT_SAME(a_err_single, m_axis_tvalid && err, m_axis_tlast && seg_len == '0 && check == '0)
  // The check digit of a valid code is a decimal digit.
  `EAN8_ASSERT_SAME(a_check_decimal, m_axis_tvalid && !err, check <= 4'd9)
  // The final segment of a valid code is the end guard.
  `EAN8_ASSERT_SAME(a_last_is_guard, m_axis_tvalid && m_axis_tlast && !err, seg_len == ean8_pkg::GuardLen && seg_bits == ean8_pkg::GuardBits)
  // A full queue always presents a code to the sequencer.
  `EAN8_ASSERT_SAME(a_full_has_item, !s_axis_tready, queue_valid)

endmodule
